### rtl/gac_pkg.sv
// ----------------------------------------------------------------------------
// gac_pkg: shared types and constants of the gapped azimuthal correlator
// Holds register reset values, register indexes, and the cosine datapath widths.
// ----------------------------------------------------------------------------
package gac_pkg;

	localparam int unsigned MAX_TRACKS_DEF = 150;
	localparam int unsigned ANGLE_BITS_DEF = 16;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PT_MIN  = 2'd0,
		CFG_ETA_MAX = 2'd1,
		CFG_ETA_GAP = 2'd2
	} cfg_idx_t;

	localparam logic [15:0] PT_MIN_RST  = 16'd77;
	localparam logic [14:0] ETA_MAX_RST = 15'd2458;
	localparam logic [14:0] ETA_GAP_RST = 15'd1229;

	// Pi/2 in Q30.
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

	localparam int unsigned TERM_W = 32;
	localparam int unsigned SUM_W  = 34;
	localparam int unsigned P_W    = 33;

	localparam int unsigned PAIR_SUM_W = 40;
	localparam int unsigned PAIR_CNT_W = 15;
	localparam int unsigned QUAD_SUM_W = 48;
	localparam int unsigned QUAD_CNT_W = 29;

	// Pipeline tag that rides along with every cosine evaluation.
	typedef struct packed {
		logic valid;
		logic quad;
	} ctl_t;

endpackage

### rtl/gapped_azimuthal_correlator.sv
// ----------------------------------------------------------------------------
// gapped_azimuthal_correlator: two- and four-particle cos(2 dphi) means with eta gap
// Selects particles, stores eta and phi, and averages the correlators per event.
// ----------------------------------------------------------------------------
// Flow: particle beats stream one per cycle while s_tready is high, which is
// only in the load state. After the last beat of an event with n kept tracks
// the sweep issues n*n*(n*n+1) cosine evaluations, one per cycle, then waits
// for the cosine chain to empty, then runs two divisions (each a start step,
// 48 quotient bits and a finish step), and presents the result once the
// output is free. A dropped event skips all of that and goes straight to the
// output. Reset: arst_n clears the control state and loads the register defaults.
// ----------------------------------------------------------------------------
module gapped_azimuthal_correlator #(
	parameter int unsigned MAX_TRACKS = gac_pkg::MAX_TRACKS_DEF,
	parameter int unsigned ANGLE_BITS = gac_pkg::ANGLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Slave side. tdata from bit 0 up: is_final_state, is_charged,
	// particle_pt[15:0], particle_eta[15:0], particle_phi[15:0], zero fill.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [55:0]                      s_tdata,
	input  logic                             s_tlast,   // last_in_event
	// Master side. tdata from bit 0 up: kept_tracks[7:0], pair_mean[15:0],
	// quad_mean[15:0]. tuser: event_dropped.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [39:0]                      m_tdata,
	output logic                             m_tuser,
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [gac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gac_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int unsigned IW = $clog2(MAX_TRACKS);
	localparam int unsigned CW = $clog2(MAX_TRACKS + 1);
	localparam int unsigned NUM_W = gac_pkg::QUAD_SUM_W;
	localparam int unsigned DEN_W = gac_pkg::QUAD_CNT_W;

	typedef enum logic [2:0] {
		ST_LOAD, ST_RUN, ST_DRAIN, ST_DIVP, ST_DIVQ, ST_OUT
	} state_t;

	// Configuration registers.
	logic [15:0] pt_min_q;
	logic [14:0] eta_max_q, eta_gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_min_q  <= gac_pkg::PT_MIN_RST;
			eta_max_q <= gac_pkg::ETA_MAX_RST;
			eta_gap_q <= gac_pkg::ETA_GAP_RST;
		end else if (cfg_we) begin
			case (gac_pkg::cfg_idx_t'(cfg_index))
				gac_pkg::CFG_PT_MIN:  pt_min_q  <= cfg_data;
				gac_pkg::CFG_ETA_MAX: eta_max_q <= cfg_data[14:0];
				gac_pkg::CFG_ETA_GAP: eta_gap_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Particle selection on the incoming beat.
	state_t state_q;
	logic [CW-1:0] total_q;
	logic overflow_q;
	logic in_acc, keep_c, store_c;
	logic [15:0] in_pt, in_eta, in_phi, eta_abs_c;

	assign s_tready  = (state_q == ST_LOAD);
	assign in_acc    = s_tvalid && s_tready;
	assign in_pt     = s_tdata[17:2];
	assign in_eta    = s_tdata[33:18];
	assign in_phi    = s_tdata[49:34];
	assign eta_abs_c = in_eta[15] ? (~in_eta + 16'd1) : in_eta;
	assign keep_c    = s_tdata[0] && s_tdata[1] && (in_pt >= pt_min_q)
		&& (eta_abs_c <= {1'b0, eta_max_q});
	assign store_c   = in_acc && keep_c && (total_q < CW'(MAX_TRACKS));

	// Four copies of the track store so that the sweep reads i, j, s and t
	// in the same cycle. Each entry is {eta, phi}.
	logic [IW-1:0] i_q, j_q, s_q, t_q;
	logic [31:0] rd_i, rd_j, rd_s, rd_t;

	gac_ram #(.WIDTH(32), .DEPTH(MAX_TRACKS)) u_ram_i (
		.clk(clk), .we(store_c), .waddr(total_q[IW-1:0]), .wdata({in_eta, in_phi}),
		.raddr(i_q), .rdata(rd_i));
	gac_ram #(.WIDTH(32), .DEPTH(MAX_TRACKS)) u_ram_j (
		.clk(clk), .we(store_c), .waddr(total_q[IW-1:0]), .wdata({in_eta, in_phi}),
		.raddr(j_q), .rdata(rd_j));
	gac_ram #(.WIDTH(32), .DEPTH(MAX_TRACKS)) u_ram_s (
		.clk(clk), .we(store_c), .waddr(total_q[IW-1:0]), .wdata({in_eta, in_phi}),
		.raddr(s_q), .rdata(rd_s));
	gac_ram #(.WIDTH(32), .DEPTH(MAX_TRACKS)) u_ram_t (
		.clk(clk), .we(store_c), .waddr(total_q[IW-1:0]), .wdata({in_eta, in_phi}),
		.raddr(t_q), .rdata(rd_t));

	// Sweep control. For each (i, j) one pair evaluation is issued, followed
	// by every (s, t) quadruple; the gap test happens in the next cycle, once the
	// store data is back, and failing tuples just lose their valid bit.
	logic quad_ph_q;
	logic issue_c, last_t_c, last_s_c, last_j_c, last_i_c;
	logic [CW-1:0] n_last_c;
	logic [4:0] drain_q;
	gac_pkg::ctl_t ctl_s1, ctl_s2;

	assign issue_c  = (state_q == ST_RUN);
	assign n_last_c = total_q - 1'b1;
	assign last_t_c = (CW'(t_q) == n_last_c);
	assign last_s_c = (CW'(s_q) == n_last_c);
	assign last_j_c = (CW'(j_q) == n_last_c);
	assign last_i_c = (CW'(i_q) == n_last_c);

	function automatic logic [ANGLE_BITS-1:0] to_ang(input logic [15:0] phi);
		if (ANGLE_BITS >= 16) begin
			return ANGLE_BITS'(phi) << ((ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0);
		end else begin
			return ANGLE_BITS'(phi >> ((ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS));
		end
	endfunction

	function automatic logic gap_ok(input logic [15:0] ea, input logic [15:0] eb,
		input logic [14:0] gap);
		logic [16:0] d;
		logic [16:0] mag;
		d   = {ea[15], ea} - {eb[15], eb};
		mag = d[16] ? (~d + 17'd1) : d;
		return mag >= {2'b00, gap};
	endfunction

	logic g_ij, g_is, g_js, g_it, g_jt, g_st, tuple_ok_c;
	logic [ANGLE_BITS-1:0] a_i, a_j, a_s, a_t, asum_c;
	logic [ANGLE_BITS-1:0] phase_s2;

	assign g_ij = gap_ok(rd_i[31:16], rd_j[31:16], eta_gap_q);
	assign g_is = gap_ok(rd_i[31:16], rd_s[31:16], eta_gap_q);
	assign g_js = gap_ok(rd_j[31:16], rd_s[31:16], eta_gap_q);
	assign g_it = gap_ok(rd_i[31:16], rd_t[31:16], eta_gap_q);
	assign g_jt = gap_ok(rd_j[31:16], rd_t[31:16], eta_gap_q);
	assign g_st = gap_ok(rd_s[31:16], rd_t[31:16], eta_gap_q);
	assign tuple_ok_c = ctl_s1.quad ? (g_ij && g_is && g_js && g_it && g_jt && g_st) : g_ij;

	assign a_i    = to_ang(rd_i[15:0]);
	assign a_j    = to_ang(rd_j[15:0]);
	assign a_s    = to_ang(rd_s[15:0]);
	assign a_t    = to_ang(rd_t[15:0]);
	assign asum_c = ctl_s1.quad ? (a_i + a_j - a_s - a_t) : (a_i - a_j);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1.valid <= issue_c;
			ctl_s1.quad  <= quad_ph_q;
			ctl_s2.valid <= ctl_s1.valid && tuple_ok_c;
			ctl_s2.quad  <= ctl_s1.quad;
		end
	end

	always_ff @(posedge clk) begin
		phase_s2 <= asum_c << 1;
	end

	gac_pkg::ctl_t cos_ctl;
	logic signed [15:0] cos_val;

	gac_cos #(.ANGLE_BITS(ANGLE_BITS)) u_cos (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (ctl_s2),
		.phase   (phase_s2),
		.out_ctl (cos_ctl),
		.cos_val (cos_val)
	);

	// Event accumulators; they wrap at their widths.
	logic [gac_pkg::PAIR_SUM_W-1:0] pair_sum_q;
	logic [gac_pkg::PAIR_CNT_W-1:0] pair_cnt_q;
	logic [gac_pkg::QUAD_SUM_W-1:0] quad_sum_q;
	logic [gac_pkg::QUAD_CNT_W-1:0] quad_cnt_q;
	logic out_free_c, evt_clear_c;

	assign out_free_c  = !m_tvalid || m_tready;
	assign evt_clear_c = (state_q == ST_OUT) && out_free_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_sum_q <= '0;
			pair_cnt_q <= '0;
			quad_sum_q <= '0;
			quad_cnt_q <= '0;
		end else if (evt_clear_c) begin
			pair_sum_q <= '0;
			pair_cnt_q <= '0;
			quad_sum_q <= '0;
			quad_cnt_q <= '0;
		end else if (cos_ctl.valid) begin
			if (cos_ctl.quad) begin
				quad_sum_q <= quad_sum_q + {{(gac_pkg::QUAD_SUM_W-16){cos_val[15]}}, cos_val};
				quad_cnt_q <= quad_cnt_q + 1'b1;
			end else begin
				pair_sum_q <= pair_sum_q + {{(gac_pkg::PAIR_SUM_W-16){cos_val[15]}}, cos_val};
				pair_cnt_q <= pair_cnt_q + 1'b1;
			end
		end
	end

	// Means: (|sum| + count/2) / count on the shared divider, then saturate
	// and restore the sign. An empty count gives zero.
	logic div_busy_q, div_start_c, div_done;
	logic [NUM_W-1:0] div_num_c, div_quo;
	logic [DEN_W-1:0] div_den_c;
	logic [gac_pkg::PAIR_SUM_W-1:0] pair_abs_c;
	logic [gac_pkg::QUAD_SUM_W-1:0] quad_abs_c;
	logic cur_neg_c, cur_zero_c;
	logic [14:0] sat_c;
	logic [15:0] mean_c;

	assign pair_abs_c = pair_sum_q[gac_pkg::PAIR_SUM_W-1] ? -pair_sum_q : pair_sum_q;
	assign quad_abs_c = quad_sum_q[gac_pkg::QUAD_SUM_W-1] ? -quad_sum_q : quad_sum_q;

	always_comb begin
		if (state_q == ST_DIVP) begin
			div_num_c  = NUM_W'(pair_abs_c) + NUM_W'(pair_cnt_q >> 1);
			div_den_c  = DEN_W'(pair_cnt_q);
			cur_neg_c  = pair_sum_q[gac_pkg::PAIR_SUM_W-1];
			cur_zero_c = (pair_cnt_q == '0);
		end else begin
			div_num_c  = quad_abs_c + NUM_W'(quad_cnt_q >> 1);
			div_den_c  = quad_cnt_q;
			cur_neg_c  = quad_sum_q[gac_pkg::QUAD_SUM_W-1];
			cur_zero_c = (quad_cnt_q == '0);
		end
	end

	assign div_start_c = ((state_q == ST_DIVP) || (state_q == ST_DIVQ)) && !div_busy_q;
	assign sat_c  = (|div_quo[NUM_W-1:15]) ? 15'h7fff : div_quo[14:0];
	assign mean_c = cur_zero_c ? 16'd0
		: (cur_neg_c ? -{1'b0, sat_c} : {1'b0, sat_c});

	gac_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_c),
		.num    (div_num_c),
		.den    (div_den_c),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Main sequencer with the output register.
	logic drop_q;
	logic [15:0] pair_mean_q, quad_mean_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			total_q     <= '0;
			overflow_q  <= 1'b0;
			drop_q      <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			s_q         <= '0;
			t_q         <= '0;
			quad_ph_q   <= 1'b0;
			drain_q     <= '0;
			div_busy_q  <= 1'b0;
			pair_mean_q <= '0;
			quad_mean_q <= '0;
			m_tvalid    <= 1'b0;
			m_tdata     <= '0;
			m_tuser     <= 1'b0;
		end else begin
			// A new result beat loaded in ST_OUT takes the place of the one
			// leaving in the same cycle.
			if (m_tvalid && m_tready && !evt_clear_c) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (store_c) begin
							total_q <= total_q + 1'b1;
						end else if (keep_c) begin
							overflow_q <= 1'b1;
						end
						if (s_tlast) begin
							i_q       <= '0;
							j_q       <= '0;
							s_q       <= '0;
							t_q       <= '0;
							quad_ph_q <= 1'b0;
							if (overflow_q || (keep_c && !store_c)) begin
								drop_q      <= 1'b1;
								pair_mean_q <= '0;
								quad_mean_q <= '0;
								state_q     <= ST_OUT;
							end else if (total_q == '0 && !store_c) begin
								drop_q  <= 1'b0;
								state_q <= ST_DIVP;
							end else begin
								drop_q  <= 1'b0;
								state_q <= ST_RUN;
							end
						end
					end
				end
				ST_RUN: begin
					if (!quad_ph_q) begin
						quad_ph_q <= 1'b1;
						s_q       <= '0;
						t_q       <= '0;
					end else if (!last_t_c) begin
						t_q <= t_q + 1'b1;
					end else begin
						t_q <= '0;
						if (!last_s_c) begin
							s_q <= s_q + 1'b1;
						end else begin
							s_q       <= '0;
							quad_ph_q <= 1'b0;
							if (!last_j_c) begin
								j_q <= j_q + 1'b1;
							end else begin
								j_q <= '0;
								if (!last_i_c) begin
									i_q <= i_q + 1'b1;
								end else begin
									drain_q <= '0;
									state_q <= ST_DRAIN;
								end
							end
						end
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (&drain_q) begin
						state_q <= ST_DIVP;
					end
				end
				ST_DIVP: begin
					if (div_start_c) begin
						div_busy_q <= 1'b1;
					end else if (div_done) begin
						div_busy_q  <= 1'b0;
						pair_mean_q <= mean_c;
						state_q     <= ST_DIVQ;
					end
				end
				ST_DIVQ: begin
					if (div_start_c) begin
						div_busy_q <= 1'b1;
					end else if (div_done) begin
						div_busy_q  <= 1'b0;
						quad_mean_q <= mean_c;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free_c) begin
						m_tvalid   <= 1'b1;
						m_tuser    <= drop_q;
						m_tdata    <= {quad_mean_q, pair_mean_q,
							drop_q ? 8'd0 : total_q[7:0]};
						total_q    <= '0;
						overflow_q <= 1'b0;
						state_q    <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// The cosine chain only carries work during the sweep and its drain.
	a_cos_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cos_ctl.valid |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("cosine result outside the sweep");

	// The store never holds more tracks than it has entries.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(MAX_TRACKS))
		else $error("track count beyond the store depth");

	// A dropped event reports zero tracks and zero means.
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("dropped event carries data");

	// Nothing is issued into the sweep while particles are still loading.
	a_no_issue_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !issue_c)
		else $error("sweep issue during load");
`endif

endmodule

### rtl/gac_ram.sv
// ----------------------------------------------------------------------------
// gac_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module gac_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 150
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/gac_cell.sv
// ----------------------------------------------------------------------------
// gac_cell: one Taylor term cell of the cosine chain
// Forms the next term as (term * x^2 >> 30) / D and folds it into the sum.
// ----------------------------------------------------------------------------
module gac_cell #(
	parameter int unsigned D        = 2,
	parameter bit          SUBTRACT = 1'b1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gac_pkg::ctl_t                       in_ctl,
	input  logic                                in_neg,
	input  logic [gac_pkg::TERM_W-1:0]          in_x2,
	input  logic [gac_pkg::TERM_W-1:0]          in_term,
	input  logic signed [gac_pkg::SUM_W-1:0]    in_sum,
	output gac_pkg::ctl_t                       out_ctl,
	output logic                                out_neg,
	output logic [gac_pkg::TERM_W-1:0]          out_x2,
	output logic [gac_pkg::TERM_W-1:0]          out_term,
	output logic signed [gac_pkg::SUM_W-1:0]    out_sum
);

	localparam int unsigned SH = gac_pkg::P_W + 7;
	localparam logic [SH-1:0] RECIP = SH'((64'd1 << SH) / D);
	localparam logic [gac_pkg::P_W-1:0] D_P = gac_pkg::P_W'(D);

	gac_pkg::ctl_t ctl_s1, ctl_s2;
	logic neg_s1, neg_s2;
	logic [gac_pkg::TERM_W-1:0] x2_s1, x2_s2;
	logic signed [gac_pkg::SUM_W-1:0] sum_s1, sum_s2;
	logic [2*gac_pkg::TERM_W-1:0] prod_s1;
	logic [gac_pkg::P_W-1:0] p_s2, qe_s2;

	logic [gac_pkg::P_W-1:0] p_c;
	logic [gac_pkg::P_W+SH-1:0] est_c;
	logic [gac_pkg::P_W-1:0] back_c, rem_c, qt_c;
	logic signed [gac_pkg::SUM_W-1:0] qt_ext_c;

	assign p_c   = prod_s1[gac_pkg::P_W+29:30];
	assign est_c = {{SH{1'b0}}, p_c} * {{gac_pkg::P_W{1'b0}}, RECIP};

	// The reciprocal estimate is low by at most one; one compare fixes it.
	assign back_c   = gac_pkg::P_W'(qe_s2 * D_P);
	assign rem_c    = p_s2 - back_c;
	assign qt_c     = (rem_c >= D_P) ? qe_s2 + 1'b1 : qe_s2;
	assign qt_ext_c = $signed({1'b0, qt_c});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			out_ctl <= '0;
		end else begin
			ctl_s1  <= in_ctl;
			ctl_s2  <= ctl_s1;
			out_ctl <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= {{gac_pkg::TERM_W{1'b0}}, in_term} * {{gac_pkg::TERM_W{1'b0}}, in_x2};
		neg_s1  <= in_neg;
		x2_s1   <= in_x2;
		sum_s1  <= in_sum;
		p_s2    <= p_c;
		qe_s2   <= est_c[gac_pkg::P_W+SH-1:SH];
		neg_s2  <= neg_s1;
		x2_s2   <= x2_s1;
		sum_s2  <= sum_s1;
		out_neg <= neg_s2;
		out_x2  <= x2_s2;
		out_term <= qt_c[gac_pkg::TERM_W-1:0];
		out_sum <= SUBTRACT ? sum_s2 - qt_ext_c : sum_s2 + qt_ext_c;
	end

endmodule

### rtl/gac_cos.sv
// ----------------------------------------------------------------------------
// gac_cos: pipelined Q15 cosine of a binary angle
// Folds the phase to the first quadrant and runs six Taylor cells in a row.
// ----------------------------------------------------------------------------
module gac_cos #(
	parameter int unsigned ANGLE_BITS = gac_pkg::ANGLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gac_pkg::ctl_t         in_ctl,
	input  logic [ANGLE_BITS-1:0] phase,
	output gac_pkg::ctl_t         out_ctl,
	output logic signed [15:0]    cos_val
);

	localparam int unsigned NCELL = 6;

	gac_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic neg_s1, neg_s2, neg_s3;
	logic [22:0] q_s1;
	logic [30:0] x_s2;
	logic [gac_pkg::TERM_W-1:0] x2_s3;

	logic [23:0] q24_c, qa_c;
	logic [22:0] qb_c;
	logic neg_c;
	logic [53:0] xw_c;
	logic [61:0] x2w_c;

	assign q24_c = 24'(phase) << (24 - ANGLE_BITS);

	always_comb begin
		qa_c  = (q24_c >= 24'h800000) ? 24'(25'h1000000 - {1'b0, q24_c}) : q24_c;
		neg_c = 1'b0;
		qb_c  = qa_c[22:0];
		if (qa_c > 24'h400000) begin
			qb_c  = 23'(24'h800000 - qa_c);
			neg_c = 1'b1;
		end
	end

	assign xw_c  = {31'd0, q_s1} * {23'd0, gac_pkg::HALF_PI_Q30};
	assign x2w_c = {31'd0, x_s2} * {31'd0, x_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		q_s1   <= qb_c;
		neg_s1 <= neg_c;
		x_s2   <= xw_c[52:22];
		neg_s2 <= neg_s1;
		x2_s3  <= x2w_c[61:30];
		neg_s3 <= neg_s2;
	end

	gac_pkg::ctl_t ch_ctl [NCELL+1];
	logic ch_neg [NCELL+1];
	logic [gac_pkg::TERM_W-1:0] ch_x2 [NCELL+1];
	logic [gac_pkg::TERM_W-1:0] ch_term [NCELL+1];
	logic signed [gac_pkg::SUM_W-1:0] ch_sum [NCELL+1];

	assign ch_ctl[0]  = ctl_s3;
	assign ch_neg[0]  = neg_s3;
	assign ch_x2[0]   = x2_s3;
	assign ch_term[0] = gac_pkg::TERM_W'(32'h40000000);
	assign ch_sum[0]  = gac_pkg::SUM_W'(34'sh040000000);

	for (genvar k = 1; k <= NCELL; k++) begin : g_cell
		gac_cell #(
			.D        ((2 * k - 1) * (2 * k)),
			.SUBTRACT ((k % 2) == 1)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_ctl   (ch_ctl[k-1]),
			.in_neg   (ch_neg[k-1]),
			.in_x2    (ch_x2[k-1]),
			.in_term  (ch_term[k-1]),
			.in_sum   (ch_sum[k-1]),
			.out_ctl  (ch_ctl[k]),
			.out_neg  (ch_neg[k]),
			.out_x2   (ch_x2[k]),
			.out_term (ch_term[k]),
			.out_sum  (ch_sum[k])
		);
	end

	logic [gac_pkg::SUM_W-1:0] pos_c, rnd_c;
	logic [14:0] mag_c;

	assign pos_c = ch_sum[NCELL][gac_pkg::SUM_W-1] ? '0 : ch_sum[NCELL];
	assign rnd_c = (pos_c + gac_pkg::SUM_W'(16384)) >> 15;
	assign mag_c = (rnd_c > gac_pkg::SUM_W'(32767)) ? 15'h7fff : rnd_c[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ctl <= '0;
		end else begin
			out_ctl <= ch_ctl[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		cos_val <= ch_neg[NCELL] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
	end

endmodule

### rtl/gac_div.sv
// ----------------------------------------------------------------------------
// gac_div: iterative restoring divider
// Produces one quotient bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module gac_div #(
	parameter int unsigned NUM_W = 48,
	parameter int unsigned DEN_W = 29
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic [DEN_W:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W+1:0] trial_c;
	logic [DEN_W:0] shifted_c;

	assign shifted_c = {rem_q[DEN_W-1:0], quo[NUM_W-1]};
	assign trial_c   = {1'b0, shifted_c} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo   <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial_c[DEN_W+1]) begin
				rem_q <= trial_c[DEN_W:0];
				quo   <= {quo[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted_c;
				quo   <= {quo[NUM_W-2:0], 1'b0};
			end
		end
	end

endmodule
